>>> rtl/tbt_pkg.sv
`default_nettype none
package tbt_pkg;

  localparam int CW   = 16;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int CXW  = PW + 1;
  localparam int LOW  = 18;
  localparam int HIW  = CXW - LOW;
  localparam int DOTW = 2 * CXW + 2;
  localparam int WF   = 16;
  localparam int WW   = WF + 2;
  localparam int QB   = WF + 4;
  localparam int RW   = DOTW + QB;
  localparam int GW   = WF + 7;
  localparam int TOLW = 16;
  localparam int QD   = 4;
  localparam int QAW  = 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_elem_t;

  typedef struct packed {
    diff_elem_t ux, uy, uz;
    diff_elem_t vx, vy, vz;
    diff_elem_t wx, wy, wz;
  } diff_t;

  typedef struct packed {
    logic            kill;
    logic            neg;
    logic            big;
    logic [DOTW-1:0] mag;
    logic [DOTW-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic          kill;
    logic          neg;
    logic          big;
    logic [QB-1:0] quo;
  } div_out_t;

endpackage
`default_nettype wire

>>> rtl/tbt_front.sv
`default_nettype none
module tbt_front (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  tbt_pkg::coord_t px, py, pz,
  input  tbt_pkg::coord_t ax, ay, az,
  input  tbt_pkg::coord_t bx, by, bz,
  input  tbt_pkg::coord_t cx, cy, cz,
  input  wire            q_full,
  output logic           push,
  output tbt_pkg::diff_t push_data
);

  logic          f_v_r, f_v_nxt;
  tbt_pkg::diff_t f_d_r;

  function automatic tbt_pkg::diff_elem_t dsub(tbt_pkg::coord_t a, tbt_pkg::coord_t b);
    return tbt_pkg::diff_elem_t'({a[tbt_pkg::CW-1], a}) -
           tbt_pkg::diff_elem_t'({b[tbt_pkg::CW-1], b});
  endfunction

  assign in_ready  = !f_v_r || !q_full;
  assign push      = f_v_r && !q_full;
  assign push_data = f_d_r;

  always_comb begin
    f_v_nxt = f_v_r;
    if (push) f_v_nxt = 1'b0;
    if (in_valid && in_ready) f_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_d_r.ux <= dsub(bx, ax);
      f_d_r.uy <= dsub(by, ay);
      f_d_r.uz <= dsub(bz, az);
      f_d_r.vx <= dsub(cx, ax);
      f_d_r.vy <= dsub(cy, ay);
      f_d_r.vz <= dsub(cz, az);
      f_d_r.wx <= dsub(px, ax);
      f_d_r.wy <= dsub(py, ay);
      f_d_r.wz <= dsub(pz, az);
    end
  end

endmodule
`default_nettype wire

>>> rtl/tbt_queue.sv
`default_nettype none
module tbt_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  tbt_pkg::diff_t push_data,
  output logic           full,
  input  wire            pop,
  output logic           not_empty,
  output tbt_pkg::diff_t head
);

  tbt_pkg::diff_t              mem_r [tbt_pkg::QD];
  logic [tbt_pkg::QAW-1:0]     wp_r, rp_r;
  logic [tbt_pkg::QAW:0]       cnt_r, cnt_nxt;

  assign full      = cnt_r == (tbt_pkg::QAW+1)'(tbt_pkg::QD);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/tbt_div.sv
`default_nettype none
module tbt_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire               in_v,
  input  tbt_pkg::div_in_t  din,
  output logic              out_v,
  output tbt_pkg::div_out_t dout
);

  logic                      v_r   [tbt_pkg::QB];
  logic [tbt_pkg::RW-1:0]    rem_r [tbt_pkg::QB];
  logic [tbt_pkg::DOTW-1:0]  den_r [tbt_pkg::QB];
  logic [tbt_pkg::QB-1:0]    quo_r [tbt_pkg::QB];
  logic [2:0]                flg_r [tbt_pkg::QB];

  logic [tbt_pkg::RW-1:0]    rem_nxt [tbt_pkg::QB];
  logic [tbt_pkg::DOTW-1:0]  den_nxt [tbt_pkg::QB];
  logic [tbt_pkg::QB-1:0]    quo_nxt [tbt_pkg::QB];
  logic [2:0]                flg_nxt [tbt_pkg::QB];

  always_comb begin
    logic [tbt_pkg::RW-1:0]   src;
    logic [tbt_pkg::RW-1:0]   sub;
    logic [tbt_pkg::QB-1:0]   qin;
    logic [tbt_pkg::DOTW-1:0] dsrc;
    for (int s = 0; s < tbt_pkg::QB; s++) begin
      if (s == 0) begin
        src  = {{tbt_pkg::QB{1'b0}}, din.mag} << tbt_pkg::WF;
        dsrc = din.den;
        qin  = '0;
        flg_nxt[s] = {din.kill, din.neg, din.big};
      end else begin
        src  = rem_r[s-1];
        dsrc = den_r[s-1];
        qin  = quo_r[s-1];
        flg_nxt[s] = flg_r[s-1];
      end
      sub = {{tbt_pkg::QB{1'b0}}, dsrc} << (tbt_pkg::QB - 1 - s);
      den_nxt[s] = dsrc;
      if (src >= sub) begin
        rem_nxt[s] = src - sub;
        quo_nxt[s] = qin | (tbt_pkg::QB'(1) << (tbt_pkg::QB - 1 - s));
      end else begin
        rem_nxt[s] = src;
        quo_nxt[s] = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < tbt_pkg::QB; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < tbt_pkg::QB; s++) v_r[s] <= (s == 0) ? in_v : v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < tbt_pkg::QB; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_nxt[s];
        quo_r[s] <= quo_nxt[s];
        flg_r[s] <= flg_nxt[s];
      end
    end
  end

  assign out_v     = v_r[tbt_pkg::QB-1];
  assign dout.kill = flg_r[tbt_pkg::QB-1][2];
  assign dout.neg  = flg_r[tbt_pkg::QB-1][1];
  assign dout.big  = flg_r[tbt_pkg::QB-1][0];
  assign dout.quo  = quo_r[tbt_pkg::QB-1];

endmodule
`default_nettype wire

>>> rtl/tbt_back.sv
`default_nettype none
module tbt_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_not_empty,
  input  tbt_pkg::diff_t               q_head,
  output logic                         pop,
  input  wire [tbt_pkg::TOLW-1:0]      tol,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         hit,
  output logic signed [tbt_pkg::WW-1:0] wa,
  output logic signed [tbt_pkg::WW-1:0] wb,
  output logic signed [tbt_pkg::WW-1:0] wc
);

  localparam int NP = 18;
  localparam int NC = 9;
  localparam int PHW = tbt_pkg::CXW + tbt_pkg::HIW;
  localparam int PLW = tbt_pkg::CXW + tbt_pkg::LOW + 1;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [tbt_pkg::PW-1:0]   pr_r [NP];
  logic signed [tbt_pkg::CXW-1:0]  cx_r [NC];
  logic signed [PHW-1:0]           ph_r [NC];
  logic signed [PLW-1:0]           pl_r [NC];
  logic signed [tbt_pkg::DOTW-1:0] pp_r [NC];
  logic signed [tbt_pkg::DOTW-1:0] nn_r, gn_r, bn_r;
  tbt_pkg::div_in_t                gdi_r, bdi_r;

  logic signed [tbt_pkg::DW-1:0] op_a [NP];
  logic signed [tbt_pkg::DW-1:0] op_b [NP];

  logic              gv, bv;
  tbt_pkg::div_out_t gdo, bdo;

  logic                          o_v_r;
  logic                          o_hit_r;
  logic signed [tbt_pkg::WW-1:0] o_a_r, o_b_r, o_c_r;

  assign en  = !o_v_r || out_ready;
  assign pop = en && q_not_empty;

  always_comb begin
    op_a[0]  = q_head.uy; op_b[0]  = q_head.vz;
    op_a[1]  = q_head.uz; op_b[1]  = q_head.vy;
    op_a[2]  = q_head.uz; op_b[2]  = q_head.vx;
    op_a[3]  = q_head.ux; op_b[3]  = q_head.vz;
    op_a[4]  = q_head.ux; op_b[4]  = q_head.vy;
    op_a[5]  = q_head.uy; op_b[5]  = q_head.vx;
    op_a[6]  = q_head.uy; op_b[6]  = q_head.wz;
    op_a[7]  = q_head.uz; op_b[7]  = q_head.wy;
    op_a[8]  = q_head.uz; op_b[8]  = q_head.wx;
    op_a[9]  = q_head.ux; op_b[9]  = q_head.wz;
    op_a[10] = q_head.ux; op_b[10] = q_head.wy;
    op_a[11] = q_head.uy; op_b[11] = q_head.wx;
    op_a[12] = q_head.wy; op_b[12] = q_head.vz;
    op_a[13] = q_head.wz; op_b[13] = q_head.vy;
    op_a[14] = q_head.wz; op_b[14] = q_head.vx;
    op_a[15] = q_head.wx; op_b[15] = q_head.vz;
    op_a[16] = q_head.wx; op_b[16] = q_head.vy;
    op_a[17] = q_head.wy; op_b[17] = q_head.vx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      v1_r  <= q_not_empty;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      o_v_r <= gv;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [tbt_pkg::CXW-1:0] ma, mb;
    logic signed [tbt_pkg::HIW-1:0] hi;
    logic signed [tbt_pkg::LOW:0]   lo;
    logic [tbt_pkg::DOTW-1:0]       gm, bm;
    if (en) begin
      for (int i = 0; i < NP; i++) pr_r[i] <= op_a[i] * op_b[i];
      for (int i = 0; i < NC; i++) begin
        cx_r[i] <= tbt_pkg::CXW'(pr_r[2*i]) - tbt_pkg::CXW'(pr_r[2*i+1]);
      end
      for (int i = 0; i < NC; i++) begin
        ma = cx_r[i];
        mb = cx_r[i % 3];
        hi = mb[tbt_pkg::CXW-1:tbt_pkg::LOW];
        lo = {1'b0, mb[tbt_pkg::LOW-1:0]};
        ph_r[i] <= ma * hi;
        pl_r[i] <= ma * lo;
      end
      for (int i = 0; i < NC; i++) begin
        pp_r[i] <= (tbt_pkg::DOTW'(ph_r[i]) <<< tbt_pkg::LOW) + tbt_pkg::DOTW'(pl_r[i]);
      end
      nn_r <= pp_r[0] + pp_r[1] + pp_r[2];
      gn_r <= pp_r[3] + pp_r[4] + pp_r[5];
      bn_r <= pp_r[6] + pp_r[7] + pp_r[8];
      gm = gn_r[tbt_pkg::DOTW-1] ? tbt_pkg::DOTW'(-gn_r) : tbt_pkg::DOTW'(gn_r);
      bm = bn_r[tbt_pkg::DOTW-1] ? tbt_pkg::DOTW'(-bn_r) : tbt_pkg::DOTW'(bn_r);
      gdi_r.kill <= nn_r == '0;
      gdi_r.neg  <= gn_r[tbt_pkg::DOTW-1];
      gdi_r.big  <= {4'b0, gm} >= ({4'b0, nn_r} << 4);
      gdi_r.mag  <= gm;
      gdi_r.den  <= nn_r;
      bdi_r.kill <= nn_r == '0;
      bdi_r.neg  <= bn_r[tbt_pkg::DOTW-1];
      bdi_r.big  <= {4'b0, bm} >= ({4'b0, nn_r} << 4);
      bdi_r.mag  <= bm;
      bdi_r.den  <= nn_r;
    end
  end

  tbt_div u_gdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .in_v (v6_r),
    .din  (gdi_r),
    .out_v(gv),
    .dout (gdo)
  );

  tbt_div u_bdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .in_v (v6_r),
    .din  (bdi_r),
    .out_v(bv),
    .dout (bdo)
  );

  always_ff @(posedge clk) begin
    logic signed [tbt_pkg::GW-1:0] g, b, a, lo_lim, hi_lim;
    logic                          ok;
    if (en) begin
      g = {3'b0, gdo.quo};
      if (gdo.neg) g = -g;
      b = {3'b0, bdo.quo};
      if (bdo.neg) b = -b;
      a = (tbt_pkg::GW'(1) <<< tbt_pkg::WF) - b - g;
      lo_lim = -$signed({7'b0, tol});
      hi_lim = (tbt_pkg::GW'(1) <<< tbt_pkg::WF) + $signed({7'b0, tol});
      ok = !gdo.kill && !gdo.big && !bdo.big && !(bv && 1'b0) &&
           a >= lo_lim && a <= hi_lim && b >= lo_lim && b <= hi_lim &&
           g >= lo_lim && g <= hi_lim;
      o_hit_r <= ok;
      o_a_r   <= ok ? a[tbt_pkg::WW-1:0] : '0;
      o_b_r   <= ok ? b[tbt_pkg::WW-1:0] : '0;
      o_c_r   <= ok ? g[tbt_pkg::WW-1:0] : '0;
    end
  end

  assign out_valid = o_v_r;
  assign hit       = o_hit_r;
  assign wa        = o_a_r;
  assign wb        = o_b_r;
  assign wc        = o_c_r;

endmodule
`default_nettype wire

>>> rtl/triangle_barycentric_test_top.sv
// Barycentric point-in-triangle test. One beat on the input channel carries
// a query point and three vertices in signed Q8.8; one beat on the output
// channel carries the hit flag and the three weights in signed Q2.16, which
// are zero on a miss or for a degenerate triangle.
// The tolerance register is written through cfg_we and cfg_wdata and resets
// to zero; the user must write it only while the block is idle, and the
// block itself does not enforce this. Throughput is one beat per cycle
// while out_ready stays high. The front stage computes edge vectors and
// feeds a four-entry queue; the back end is a fixed pipeline of six
// arithmetic stages, twenty restoring division stages (one quotient bit per
// stage) and an output register.
// Reset empties the queue and all pipeline stages. When the receiver holds
// out_ready low with an output beat waiting, the whole back end freezes,
// the queue fills and in_ready drops; no beat is lost or repeated.
`default_nettype none
module triangle_barycentric_test_top (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [15:0]             in_query_x,
  input  wire signed [15:0]             in_query_y,
  input  wire signed [15:0]             in_query_z,
  input  wire signed [15:0]             in_vert0_x,
  input  wire signed [15:0]             in_vert0_y,
  input  wire signed [15:0]             in_vert0_z,
  input  wire signed [15:0]             in_vert1_x,
  input  wire signed [15:0]             in_vert1_y,
  input  wire signed [15:0]             in_vert1_z,
  input  wire signed [15:0]             in_vert2_x,
  input  wire signed [15:0]             in_vert2_y,
  input  wire signed [15:0]             in_vert2_z,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_hit,
  output logic signed [17:0]            out_weight_a,
  output logic signed [17:0]            out_weight_b,
  output logic signed [17:0]            out_weight_c,
  input  wire                           cfg_we,
  input  wire [15:0]                    cfg_wdata
);

  logic [tbt_pkg::TOLW-1:0] tol_r;
  logic                     q_full, push, pop, q_ne;
  tbt_pkg::diff_t           push_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  tbt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .px       (in_query_x),
    .py       (in_query_y),
    .pz       (in_query_z),
    .ax       (in_vert0_x),
    .ay       (in_vert0_y),
    .az       (in_vert0_z),
    .bx       (in_vert1_x),
    .by       (in_vert1_y),
    .bz       (in_vert1_z),
    .cx       (in_vert2_x),
    .cy       (in_vert2_y),
    .cz       (in_vert2_z),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  tbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_ne),
    .head     (q_head)
  );

  tbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_ne),
    .q_head     (q_head),
    .pop        (pop),
    .tol        (tol_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (out_hit),
    .wa         (out_weight_a),
    .wb         (out_weight_b),
    .wc         (out_weight_c)
  );

endmodule
`default_nettype wire

>>> bench/triangle_barycentric_checker.sv
`timescale 1ns / 1ps
module triangle_barycentric_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  tbt_pkg::coord_t    in_query_x,
  input  tbt_pkg::coord_t    in_query_y,
  input  tbt_pkg::coord_t    in_query_z,
  input  tbt_pkg::coord_t    in_vert0_x,
  input  tbt_pkg::coord_t    in_vert0_y,
  input  tbt_pkg::coord_t    in_vert0_z,
  input  tbt_pkg::coord_t    in_vert1_x,
  input  tbt_pkg::coord_t    in_vert1_y,
  input  tbt_pkg::coord_t    in_vert1_z,
  input  tbt_pkg::coord_t    in_vert2_x,
  input  tbt_pkg::coord_t    in_vert2_y,
  input  tbt_pkg::coord_t    in_vert2_z,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire                out_hit,
  input  wire signed [17:0]  out_weight_a,
  input  wire signed [17:0]  out_weight_b,
  input  wire signed [17:0]  out_weight_c,
  input  wire                cfg_we,
  input  wire [15:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [159:0] exact_t;

  typedef struct {
    logic              hit;
    logic signed [17:0] wa, wb, wc;
  } weights_t;

  weights_t   expected_weights[$];
  logic [15:0] tol_reg;

  function automatic exact_t weight_quotient(exact_t num, exact_t den);
    exact_t q;
    exact_t cap;
    cap = exact_t'(1) <<< 19;
    q = (num <<< 16) / den;
    if (q > cap) q = cap;
    if (q < -cap) q = -cap;
    return q;
  endfunction

  function automatic weights_t barycentric_weights(tbt_pkg::coord_t c[12], logic [15:0] tol);
    exact_t u[3], v[3], w[3], n[3], cu[3], cv[3];
    exact_t nn, a, b, g, one, t;
    weights_t r;
    for (int i = 0; i < 3; i++) begin
      u[i] = exact_t'(c[6+i]) - exact_t'(c[3+i]);
      v[i] = exact_t'(c[9+i]) - exact_t'(c[3+i]);
      w[i] = exact_t'(c[i]) - exact_t'(c[3+i]);
    end
    n[0] = u[1]*v[2] - u[2]*v[1];
    n[1] = u[2]*v[0] - u[0]*v[2];
    n[2] = u[0]*v[1] - u[1]*v[0];
    cu[0] = u[1]*w[2] - u[2]*w[1];
    cu[1] = u[2]*w[0] - u[0]*w[2];
    cu[2] = u[0]*w[1] - u[1]*w[0];
    cv[0] = w[1]*v[2] - w[2]*v[1];
    cv[1] = w[2]*v[0] - w[0]*v[2];
    cv[2] = w[0]*v[1] - w[1]*v[0];
    nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    r.hit = 1'b0;
    r.wa = '0;
    r.wb = '0;
    r.wc = '0;
    if (nn == 0) return r;
    g = weight_quotient(cu[0]*n[0] + cu[1]*n[1] + cu[2]*n[2], nn);
    b = weight_quotient(cv[0]*n[0] + cv[1]*n[1] + cv[2]*n[2], nn);
    one = exact_t'(65536);
    a = one - b - g;
    t = exact_t'({1'b0, tol});
    if (a >= -t && a <= one + t && b >= -t && b <= one + t && g >= -t && g <= one + t) begin
      r.hit = 1'b1;
      r.wa = a[17:0];
      r.wb = b[17:0];
      r.wc = g[17:0];
    end
    return r;
  endfunction

  assign pending = expected_weights.size();

  always @(posedge clk) begin
    tbt_pkg::coord_t c[12];
    weights_t e;
    if (!rst_n) begin
      expected_weights.delete();
      tol_reg = '0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        c = '{in_query_x, in_query_y, in_query_z, in_vert0_x, in_vert0_y, in_vert0_z,
              in_vert1_x, in_vert1_y, in_vert1_z, in_vert2_x, in_vert2_y, in_vert2_z};
        expected_weights.push_back(barycentric_weights(c, tol_reg));
      end
      if (out_valid && out_ready) begin
        if (expected_weights.size() == 0) begin
          $error("output beat with no expected result");
          fail_count++;
        end else begin
          e = expected_weights.pop_front();
          if (out_hit !== e.hit) begin
            $error("hit: expected %0d, actual %0d", e.hit, out_hit);
            fail_count++;
          end
          if (out_weight_a !== e.wa) begin
            $error("weight_a: expected %0d, actual %0d", e.wa, out_weight_a);
            fail_count++;
          end
          if (out_weight_b !== e.wb) begin
            $error("weight_b: expected %0d, actual %0d", e.wb, out_weight_b);
            fail_count++;
          end
          if (out_weight_c !== e.wc) begin
            $error("weight_c: expected %0d, actual %0d", e.wc, out_weight_c);
            fail_count++;
          end
        end
      end
      if (cfg_we) tol_reg = cfg_wdata;
    end
  end

endmodule

>>> bench/tb_triangle_barycentric_test_top.sv
`timescale 1ns / 1ps
module tb_triangle_barycentric_test_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tbt_pkg::coord_t pt[12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [17:0] out_weight_a, out_weight_b, out_weight_c;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  logic hold_req = 1'b0;
  logic in_accepted = 1'b0;

  initial for (int i = 0; i < 12; i++) pt[i] = '0;

  always #6 clk = ~clk;

  triangle_barycentric_test_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_query_x(pt[0]), .in_query_y(pt[1]), .in_query_z(pt[2]),
    .in_vert0_x(pt[3]), .in_vert0_y(pt[4]), .in_vert0_z(pt[5]),
    .in_vert1_x(pt[6]), .in_vert1_y(pt[7]), .in_vert1_z(pt[8]),
    .in_vert2_x(pt[9]), .in_vert2_y(pt[10]), .in_vert2_z(pt[11]),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_weight_a(out_weight_a), .out_weight_b(out_weight_b),
    .out_weight_c(out_weight_c),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  triangle_barycentric_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_query_x(pt[0]), .in_query_y(pt[1]), .in_query_z(pt[2]),
    .in_vert0_x(pt[3]), .in_vert0_y(pt[4]), .in_vert0_z(pt[5]),
    .in_vert1_x(pt[6]), .in_vert1_y(pt[7]), .in_vert1_z(pt[8]),
    .in_vert2_x(pt[9]), .in_vert2_y(pt[10]), .in_vert2_z(pt[11]),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_weight_a(out_weight_a), .out_weight_b(out_weight_b),
    .out_weight_c(out_weight_c),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) in_accepted <= in_valid && in_ready;

  always @(negedge clk) begin
    if (hold_req) begin
      out_ready = 1'b0;
      repeat (300) @(negedge clk);
      hold_req = 1'b0;
    end
    out_ready = rst_n && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_triangle(tbt_pkg::coord_t c[12]);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    pt = c;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_accepted);
    in_valid = 1'b0;
  endtask

  function automatic tbt_pkg::coord_t rnd_coord(int span);
    return tbt_pkg::coord_t'($urandom_range(2 * span) - span);
  endfunction

  task automatic send_random_triangle();
    tbt_pkg::coord_t c[12];
    int kind, ka, kb;
    int u[3], v[3];
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      c[3+i] = rnd_coord(3000);
      u[i] = int'($urandom_range(4000)) - 2000;
      v[i] = int'($urandom_range(4000)) - 2000;
      c[6+i] = tbt_pkg::coord_t'(c[3+i] + u[i]);
      c[9+i] = tbt_pkg::coord_t'(c[3+i] + v[i]);
    end
    ka = int'($urandom_range(12)) - 2;
    kb = int'($urandom_range(12)) - 2;
    for (int i = 0; i < 3; i++)
      c[i] = tbt_pkg::coord_t'(c[3+i] + (ka * u[i] + kb * v[i]) / 8 +
                               int'($urandom_range(6)) - 3);
    if (kind == 7) begin
      for (int i = 0; i < 3; i++) c[9+i] = tbt_pkg::coord_t'(c[3+i] + 2 * u[i]);
    end else if (kind >= 8) begin
      for (int i = 0; i < 12; i++) c[i] = tbt_pkg::coord_t'($urandom);
    end
    send_triangle(c);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    @(negedge clk);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic directed_triangles();
    tbt_pkg::coord_t c[12];
    tbt_pkg::coord_t mx = 16'sh7fff, mn = -16'sh8000;
    c = '{default: '0};
    send_triangle(c);
    c = '{0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{64, 64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{128, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{-1, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{257, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{100, 100, 500, 0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(c);
    c = '{mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn};
    send_triangle(c);
    c = '{mn, mn, mn, mn, mn, mn, mx, mn, mn, mn, mx, mn};
    send_triangle(c);
    c = '{0, 0, 0, mn, mn, mn, mx, mx, mn, mn, mx, mx};
    send_triangle(c);
    c = '{mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx, mn};
    send_triangle(c);
    c = '{mx, mx, mx, 0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(c);
    c = '{mn, mn, mn, 0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(c);
    c = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5};
    send_triangle(c);
    c = '{0, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2};
    send_triangle(c);
    c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_triangle(c);
    c = '{0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 0, 100};
    send_triangle(c);
  endtask

  initial begin
    #5_000_000;
    $display("** triangle_barycentric_test_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    write_tolerance(16'h0000);
    send_idle = 34;
    recv_idle = 67;
    directed_triangles();
    repeat (180) send_random_triangle();
    drain();
    write_tolerance(16'hffff);
    send_idle = 67;
    recv_idle = 34;
    directed_triangles();
    repeat (180) send_random_triangle();
    drain();
    write_tolerance(16'($urandom));
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    repeat (200) send_random_triangle();
    drain();
    write_tolerance(16'h0800);
    send_idle = 34;
    recv_idle = 67;
    repeat (180) send_random_triangle();
    drain();
    if (fail_count == 0) begin
      $display("** triangle_barycentric_test_top: PASSED **");
    end else begin
      $display("** triangle_barycentric_test_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> triangle_barycentric_test_top.f
rtl/tbt_pkg.sv
rtl/tbt_front.sv
rtl/tbt_queue.sv
rtl/tbt_div.sv
rtl/tbt_back.sv
rtl/triangle_barycentric_test_top.sv
bench/triangle_barycentric_checker.sv
bench/tb_triangle_barycentric_test_top.sv
